// ===== rtl/core/stc_pkg.sv =====
package stc_pkg;

	// Level datapath width (levels and steps are unsigned, no implied fraction)
	localparam int LevelBits = 16;

	// Clamped moves in a row that count as a reversal
	localparam logic [3:0] MaxLimitHits = 4'd2;

	// Trial count at which a measurement is complete
	localparam logic [7:0] MaxTrials = 8'd150;

	typedef logic [LevelBits-1:0] level_t;

	// Last move direction
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MIN_LEVEL     = 3'd0,
		REG_MAX_LEVEL     = 3'd1,
		REG_MIN_STEP      = 3'd2,
		REG_INIT_LEVEL    = 3'd3,
		REG_INIT_STEP     = 3'd4,
		REG_NUM_UP        = 3'd5,
		REG_NUM_DOWN      = 3'd6,
		REG_MAX_REVERSALS = 3'd7
	} reg_idx_t;

	// Input function codes
	localparam logic FUNC_RESPONSE = 1'b0;
	localparam logic FUNC_START    = 1'b1;

	// Configuration register set
	typedef struct packed {
		level_t     min_level;
		level_t     max_level;
		level_t     min_step;
		level_t     init_level;
		level_t     init_step;
		logic [3:0] num_up;
		logic [3:0] num_down;
		logic [7:0] max_reversals;
	} cfg_t;

	// One result transaction
	typedef struct packed {
		level_t     level;
		logic [7:0] reversals;
		logic [7:0] trials;
		logic       complete;
	} result_t;

	// Four-bit saturating increment
	function automatic logic [3:0] sat_inc4(input logic [3:0] v);
		sat_inc4 = (v == 4'hF) ? v : v + 4'd1;
	endfunction

endpackage

// ===== rtl/core/stc_if.sv =====
// Response/start channel
interface stc_in_if;
	logic valid;
	logic ready;
	logic func;
	logic correct;

	modport source (output valid, output func, output correct, input ready);
	modport sink   (input valid, input func, input correct, output ready);
endinterface

// Result channel
interface stc_out_if;
	logic                valid;
	logic                ready;
	stc_pkg::level_t     level;
	logic [7:0]          reversals;
	logic [7:0]          trials;
	logic                complete;

	modport source (output valid, output level, output reversals, output trials,
		output complete, input ready);
	modport sink   (input valid, input level, input reversals, input trials,
		input complete, output ready);
endinterface

// ===== rtl/core/stc_cfg_regs.sv =====
module stc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  stc_pkg::level_t     cfg_data,
	output stc_pkg::cfg_t       cfg
);

	stc_pkg::cfg_t cfg_q;

	// Register file, written one register per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_level     <= 16'd0;
			cfg_q.max_level     <= 16'hFFFF;
			cfg_q.min_step      <= 16'd256;
			cfg_q.init_level    <= 16'hFFFF;
			cfg_q.init_step     <= 16'd1024;
			cfg_q.num_up        <= 4'd1;
			cfg_q.num_down      <= 4'd2;
			cfg_q.max_reversals <= 8'd50;
		end else if (cfg_wr_en) begin
			case (stc_pkg::reg_idx_t'(cfg_index))
				stc_pkg::REG_MIN_LEVEL:     cfg_q.min_level     <= cfg_data;
				stc_pkg::REG_MAX_LEVEL:     cfg_q.max_level     <= cfg_data;
				stc_pkg::REG_MIN_STEP:      cfg_q.min_step      <= cfg_data;
				stc_pkg::REG_INIT_LEVEL:    cfg_q.init_level    <= cfg_data;
				stc_pkg::REG_INIT_STEP:     cfg_q.init_step     <= cfg_data;
				stc_pkg::REG_NUM_UP:        cfg_q.num_up        <= cfg_data[3:0];
				stc_pkg::REG_NUM_DOWN:      cfg_q.num_down      <= cfg_data[3:0];
				stc_pkg::REG_MAX_REVERSALS: cfg_q.max_reversals <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/stc_update.sv =====
module stc_update (
	input  logic                clk,
	input  logic                arst_n,
	input  stc_pkg::cfg_t       cfg,
	input  logic                take,
	input  logic                func,
	input  logic                correct,
	output stc_pkg::result_t    res
);

	localparam int LB = stc_pkg::LevelBits;

	// Tracking state
	stc_pkg::level_t level_q, step_q;
	logic [3:0]      up_run_q, down_run_q, hits_q;
	stc_pkg::dir_t   dir_q;
	logic [7:0]      rev_q, trials_q;

	// Next state
	stc_pkg::level_t level_d, step_d, start_level, halved, step_eff;
	logic [3:0]      up_run_d, down_run_d, hits_d, up_inc, down_inc, hits_inc;
	stc_pkg::dir_t   dir_d;
	logic [7:0]      rev_d, trials_d;
	logic            mv_up, mv_down, dir_rev, limit_rev, clamped;
	logic [LB:0]     up_sum;
	stc_pkg::level_t dn_diff, up_level, dn_level;
	logic            up_clamp, dn_clamp;
	logic [8:0]      rev_sum;

	// Start level clamp: minimum tested first
	always_comb begin
		if (cfg.init_level < cfg.min_level)
			start_level = cfg.min_level;
		else if (cfg.init_level > cfg.max_level)
			start_level = cfg.max_level;
		else
			start_level = cfg.init_level;
	end

	// Run counters and move decision
	assign up_inc   = stc_pkg::sat_inc4(up_run_q);
	assign down_inc = stc_pkg::sat_inc4(down_run_q);
	assign mv_up    = !correct && (up_inc == cfg.num_up);
	assign mv_down  = correct && (down_inc == cfg.num_down);

	// Reversal on direction change halves the step, floored at min_step
	assign dir_rev  = (mv_up && dir_q == stc_pkg::DIR_DOWN) ||
		(mv_down && dir_q == stc_pkg::DIR_UP);
	assign halved   = step_q >> 1;
	assign step_eff = !dir_rev ? step_q :
		((halved < cfg.min_step) ? cfg.min_step : halved);

	// Candidate levels with clamping
	assign up_sum   = {1'b0, level_q} + {1'b0, step_eff};
	assign up_clamp = up_sum[LB] || (up_sum[LB-1:0] > cfg.max_level);
	assign up_level = up_clamp ? cfg.max_level : up_sum[LB-1:0];
	assign dn_diff  = level_q - step_eff;
	assign dn_clamp = (step_eff > level_q) || (dn_diff < cfg.min_level);
	assign dn_level = dn_clamp ? cfg.min_level : dn_diff;
	assign clamped  = mv_up ? up_clamp : dn_clamp;

	// Limit-hit counter
	assign hits_inc  = stc_pkg::sat_inc4(hits_q);
	assign limit_rev = (mv_up || mv_down) && clamped && (hits_inc >= stc_pkg::MaxLimitHits);

	// Reversal total, saturating; up to two reversals per response
	assign rev_sum = {1'b0, rev_q} + {7'd0, dir_rev} + {7'd0, limit_rev};

	always_comb begin
		level_d    = level_q;
		step_d     = step_q;
		up_run_d   = up_run_q;
		down_run_d = down_run_q;
		hits_d     = hits_q;
		dir_d      = dir_q;
		rev_d      = rev_q;
		trials_d   = trials_q;
		if (func == stc_pkg::FUNC_START) begin
			level_d    = start_level;
			step_d     = cfg.init_step;
			up_run_d   = 4'd0;
			down_run_d = 4'd0;
			hits_d     = 4'd0;
			dir_d      = stc_pkg::DIR_NONE;
			rev_d      = 8'd0;
			trials_d   = 8'd0;
		end else begin
			trials_d = (trials_q == 8'hFF) ? trials_q : trials_q + 8'd1;
			rev_d    = rev_sum[8] ? 8'hFF : rev_sum[7:0];
			if (!correct) begin
				up_run_d   = mv_up ? 4'd0 : up_inc;
				down_run_d = 4'd0;
			end else begin
				down_run_d = mv_down ? 4'd0 : down_inc;
				up_run_d   = 4'd0;
			end
			if (mv_up || mv_down) begin
				step_d  = step_eff;
				level_d = mv_up ? up_level : dn_level;
				dir_d   = mv_up ? stc_pkg::DIR_UP : stc_pkg::DIR_DOWN;
				if (!clamped)
					hits_d = 4'd0;
				else if (limit_rev)
					hits_d = 4'd0;
				else
					hits_d = hits_inc;
			end
		end
	end

	// State update on each accepted transaction; reset is a start with reset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= 16'hFFFF;
			step_q     <= 16'd1024;
			up_run_q   <= 4'd0;
			down_run_q <= 4'd0;
			hits_q     <= 4'd0;
			dir_q      <= stc_pkg::DIR_NONE;
			rev_q      <= 8'd0;
			trials_q   <= 8'd0;
		end else if (take) begin
			level_q    <= level_d;
			step_q     <= step_d;
			up_run_q   <= up_run_d;
			down_run_q <= down_run_d;
			hits_q     <= hits_d;
			dir_q      <= dir_d;
			rev_q      <= rev_d;
			trials_q   <= trials_d;
		end
	end

	// Result view of the post-update state
	assign res.level     = level_d;
	assign res.reversals = rev_d;
	assign res.trials    = trials_d;
	assign res.complete  = (rev_d >= cfg.max_reversals) || (trials_d >= stc_pkg::MaxTrials);

endmodule

// ===== rtl/core/adaptive_up_down_staircase.sv =====
// Adaptive N-up/M-down staircase.
// in_ch carries one transaction per trial: func selects a start (reload the
// starting level and step, clear all counts) or a response, with correct
// giving the answer. res_ch returns exactly one result per input
// transaction: the level to present next, reversal and trial counts and the
// complete flag. Registers are written through cfg_wr_en / cfg_index /
// cfg_data and take effect at the next start or move; write them only while
// no transaction is in flight.
// Latency: the result is valid the cycle after the input is accepted.
// Throughput: one transaction per cycle unless stalled; the update is one
// pass of adds, compares and a one-bit shift between state and result registers.
// Reset: registers take their default values and the tracking state is that
// of a start with those defaults; no result is pending.
// Stall: the result register holds while res_ch.ready is low, and
// in_ch.ready drops only while a held result is not being taken.
module adaptive_up_down_staircase (
	input  logic             clk,
	input  logic             arst_n,
	stc_in_if.sink           in_ch,
	stc_out_if.source        res_ch,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_index,
	input  stc_pkg::level_t  cfg_data
);

	stc_pkg::cfg_t    cfg;
	stc_pkg::result_t res_next;
	stc_pkg::result_t res_q;
	logic             res_valid_q;
	logic             take;

	stc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input handshake: free when the result register is empty or draining
	assign in_ch.ready = !res_valid_q || res_ch.ready;
	assign take        = in_ch.valid && in_ch.ready;

	stc_update u_upd (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.take    (take),
		.func    (in_ch.func),
		.correct (in_ch.correct),
		.res     (res_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (take)
			res_valid_q <= 1'b1;
		else if (res_ch.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			res_q <= res_next;
	end

	assign res_ch.valid     = res_valid_q;
	assign res_ch.level     = res_q.level;
	assign res_ch.reversals = res_q.reversals;
	assign res_ch.trials    = res_q.trials;
	assign res_ch.complete  = res_q.complete;

	// A start transaction yields a result with cleared counts
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_ch.func == stc_pkg::FUNC_START |=>
		res_ch.valid && res_ch.trials == 8'd0 && res_ch.reversals == 8'd0)
		else $error("start did not clear counts");

	// A held, stalled result blocks new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && !res_ch.ready |-> !in_ch.ready)
		else $error("input accepted over a stalled result");

	// Complete flag agrees with the counts it summarizes
	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> res_ch.complete ==
		((res_ch.reversals >= cfg.max_reversals) || (res_ch.trials >= stc_pkg::MaxTrials)))
		else $error("complete flag inconsistent");

endmodule
